// ===== design/block_bitmap_allocator_macros.svh =====
// assertion macros for the block bitmap allocator
// included by the files that carry concurrent assertions, no other dependencies
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// shared types and constants for the block bitmap allocator
// no dependencies
package bba_pkg;

	localparam int BLK_W                     = 12;
	localparam int CFG_W                     = 13;
	localparam int WORD_W                    = 32;
	localparam int BIT_W                     = 5;
	localparam int RESERVED_BLOCKS           = 2;
	localparam int FIELD_LIMIT               = 4096;
	localparam int RECIP_SHIFT               = 26;
	localparam int DEF_MAX_BLOCKS            = 4096;
	localparam int DEF_BITS_PER_BITMAP_BLOCK = 32768;
	localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

	typedef enum logic [1:0] {
		MODE_QUERY,
		MODE_MARK_USED,
		MODE_MARK_FREE,
		MODE_ALLOC
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NO_FREE,
		STAT_ZERO_REFUSED,
		STAT_RANGE
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOOK,
		ST_START,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [BLK_W-1:0]  block_number;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic              was_free;
		logic [BLK_W-1:0]  result_block;
	} out_t;

endpackage

// ===== design/block_bitmap_allocator.sv =====
// Free-block bitmap with first-fit allocation, one bit per block (1 = free), all blocks
// used after reset. Words are taken on in_valid/in_ready one at a time: query, mark used
// and mark free read the bitmap word in PREP and set the result in LOOK, where the marks
// write the word back; allocate passes START, then scans the bitmap one 32-bit word per cycle
// through the single read port of the bitmap ram, up to the first free block or the
// last word of the bound. A new word is accepted once the previous result is in the
// output register, so a held output adds its stall to the next word.
// There is no clearing pass after reset: each bitmap word has a valid flop and reads as
// all-used until first written. total_blocks is clamped to min(MAX_BLOCKS, 4096).
// depends on bba_pkg, bba_ram and block_bitmap_allocator_macros.svh
`include "block_bitmap_allocator_macros.svh"

module block_bitmap_allocator #(
	parameter int MAX_BLOCKS            = bba_pkg::DEF_MAX_BLOCKS,
	parameter int BITS_PER_BITMAP_BLOCK = bba_pkg::DEF_BITS_PER_BITMAP_BLOCK
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bba_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bba_pkg::out_t              out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bba_pkg::CFG_W-1:0]  cfg_data
);

	localparam int CW     = bba_pkg::CFG_W;
	localparam int WW     = bba_pkg::WORD_W;
	localparam int BW     = bba_pkg::BIT_W;
	localparam int LIMIT  = (MAX_BLOCKS < bba_pkg::FIELD_LIMIT) ? MAX_BLOCKS
		: bba_pkg::FIELD_LIMIT;
	localparam int DEPTH  = (LIMIT + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
	localparam int AW     = $clog2(DEPTH);
	localparam bit BPB_BIG = BITS_PER_BITMAP_BLOCK >= bba_pkg::FIELD_LIMIT;
	localparam longint unsigned RECIP =
		((64'd1 << bba_pkg::RECIP_SHIFT) + BITS_PER_BITMAP_BLOCK - 1) / BITS_PER_BITMAP_BLOCK;
	localparam int RW     = $clog2(RECIP + 1);
	localparam int PW     = CW + RW;
	localparam int BPB_M1 = BPB_BIG ? 0 : BITS_PER_BITMAP_BLOCK - 1;

	bba_pkg::state_t          state_q, state_d;
	logic [CW-1:0]            total_q;
	logic [CW-1:0]            bound;
	logic [CW-1:0]            ceil_x;
	logic [PW-1:0]            ceil_prod;
	logic [CW-1:0]            ceil_q;
	logic [CW-1:0]            first_q;
	bba_pkg::mode_t           mode_q;
	logic [bba_pkg::BLK_W-1:0] blk_q;
	logic [AW-1:0]            addr_q;
	logic [AW-1:0]            last_q;
	logic [AW-1:0]            first_word_q;
	logic                     iss_done_q;
	logic                     chk_s1;
	logic [AW-1:0]            chk_addr_s1;
	logic                     rd_vld_s1;
	logic [DEPTH-1:0]         vld_q;
	bba_pkg::out_t            res_q, res_d;
	logic                     res_ld;
	bba_pkg::out_t            out_q;
	logic                     out_valid_q;

	logic                     ram_we, ram_re;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [WW-1:0]            ram_wdata, ram_rdata, word;
	logic [WW-1:0]            lo_mask, hi_mask, masked;
	logic                     scan_hit;
	logic [BW-1:0]            hit_idx;
	logic [BW-1:0]            bit_idx;
	logic                     blk_in_range;

	bba_ram #(
		.WIDTH (WW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// working bound and first data block
	assign bound     = (total_q > CW'(LIMIT)) ? CW'(LIMIT) : total_q;
	assign ceil_x    = bound + CW'(BPB_M1);
	assign ceil_prod = PW'(ceil_x) * PW'(RECIP);
	assign ceil_q    = BPB_BIG ? CW'(bound != '0) : CW'(ceil_prod >> bba_pkg::RECIP_SHIFT);

	assign word         = rd_vld_s1 ? ram_rdata : '0;
	assign bit_idx      = blk_q[BW-1:0];
	assign blk_in_range = {1'b0, blk_q} < bound;

	// scan masks for the edge words of the range
	always_comb begin
		lo_mask = '1;
		hi_mask = '1;
		if (chk_addr_s1 == first_word_q) begin
			lo_mask = ~((WW'(1) << first_q[BW-1:0]) - WW'(1));
		end
		if (chk_addr_s1 == last_q && bound[BW-1:0] != '0) begin
			hi_mask = (WW'(1) << bound[BW-1:0]) - WW'(1);
		end
		masked   = word & lo_mask & hi_mask;
		scan_hit = chk_s1 && (masked != '0);
	end

	// lowest set bit
	always_comb begin
		hit_idx = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (masked[i]) begin
				hit_idx = BW'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = AW'(blk_q >> BW);
		ram_wdata = word;
		ram_re    = 1'b0;
		ram_raddr = AW'(blk_q >> BW);
		res_ld    = 1'b0;
		res_d     = res_q;
		case (state_q)
			bba_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bba_pkg::ST_PREP;
				end
			end
			bba_pkg::ST_PREP: begin
				ram_re  = (mode_q != bba_pkg::MODE_ALLOC) && (blk_in_range || blk_q == '0);
				state_d = (mode_q == bba_pkg::MODE_ALLOC) ? bba_pkg::ST_START
					: bba_pkg::ST_LOOK;
			end
			bba_pkg::ST_LOOK: begin
				res_ld                = 1'b1;
				res_d.result_block    = blk_q;
				if (mode_q != bba_pkg::MODE_QUERY && blk_q == '0) begin
					res_d.status   = bba_pkg::STAT_ZERO_REFUSED;
					res_d.was_free = word[bit_idx];
				end else if (!blk_in_range) begin
					res_d.status   = bba_pkg::STAT_RANGE;
					res_d.was_free = 1'b0;
				end else begin
					res_d.status   = bba_pkg::STAT_OK;
					res_d.was_free = word[bit_idx];
					if (mode_q == bba_pkg::MODE_MARK_USED) begin
						ram_we    = 1'b1;
						ram_wdata = word & ~(WW'(1) << bit_idx);
					end else if (mode_q == bba_pkg::MODE_MARK_FREE) begin
						ram_we    = 1'b1;
						ram_wdata = word | (WW'(1) << bit_idx);
					end
				end
				state_d = bba_pkg::ST_DONE;
			end
			bba_pkg::ST_START: begin
				if (first_q >= bound) begin
					res_ld             = 1'b1;
					res_d.status       = bba_pkg::STAT_NO_FREE;
					res_d.was_free     = 1'b0;
					res_d.result_block = '0;
					state_d            = bba_pkg::ST_DONE;
				end else begin
					state_d = bba_pkg::ST_SCAN;
				end
			end
			bba_pkg::ST_SCAN: begin
				ram_re    = !iss_done_q;
				ram_raddr = addr_q;
				if (scan_hit) begin
					ram_we             = 1'b1;
					ram_waddr          = chk_addr_s1;
					ram_wdata          = word & ~(WW'(1) << hit_idx);
					res_ld             = 1'b1;
					res_d.status       = bba_pkg::STAT_OK;
					res_d.was_free     = 1'b1;
					res_d.result_block = bba_pkg::BLK_W'({chk_addr_s1, hit_idx});
					state_d            = bba_pkg::ST_DONE;
				end else if (chk_s1 && chk_addr_s1 == last_q) begin
					res_ld             = 1'b1;
					res_d.status       = bba_pkg::STAT_NO_FREE;
					res_d.was_free     = 1'b0;
					res_d.result_block = '0;
					state_d            = bba_pkg::ST_DONE;
				end
			end
			bba_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= bba_pkg::TOTAL_RESET;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			iss_done_q  <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == bba_pkg::ST_DONE && state_d == bba_pkg::ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == bba_pkg::ST_START) begin
				iss_done_q <= 1'b0;
				chk_s1     <= 1'b0;
			end else if (state_q == bba_pkg::ST_SCAN) begin
				if (ram_re && addr_q == last_q) begin
					iss_done_q <= 1'b1;
				end
				chk_s1 <= ram_re;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		first_q <= CW'(bba_pkg::RESERVED_BLOCKS) + ceil_q;
		if (in_valid && in_ready) begin
			mode_q <= in_data.mode;
			blk_q  <= in_data.block_number;
		end
		if (ram_re) begin
			rd_vld_s1 <= vld_q[ram_raddr];
		end
		if (state_q == bba_pkg::ST_START) begin
			addr_q       <= AW'(first_q >> BW);
			first_word_q <= AW'(first_q >> BW);
			last_q       <= AW'((bound - CW'(1)) >> BW);
		end else if (state_q == bba_pkg::ST_SCAN && ram_re) begin
			addr_q      <= addr_q + AW'(1);
			chk_addr_s1 <= addr_q;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == bba_pkg::ST_DONE && state_d == bba_pkg::ST_IDLE) begin
			out_q <= res_q;
		end
	end

	assign in_ready  = (state_q == bba_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BBA_ASSERT_NXT(a_accept_prep, clk, arst_n, in_valid && in_ready, state_q == bba_pkg::ST_PREP, "accepted word did not start work")
	`BBA_ASSERT_IMP(a_write_state, clk, arst_n, ram_we, state_q == bba_pkg::ST_LOOK || state_q == bba_pkg::ST_SCAN, "bitmap written outside look or scan")
	`BBA_ASSERT_NXT(a_hit_done, clk, arst_n, state_q == bba_pkg::ST_SCAN && scan_hit, state_q == bba_pkg::ST_DONE, "scan kept going after a hit")
	`BBA_ASSERT_IMP(a_alloc_ok, clk, arst_n, state_q == bba_pkg::ST_DONE && mode_q == bba_pkg::MODE_ALLOC && res_q.status == bba_pkg::STAT_OK, res_q.was_free && res_q.result_block > 12'd1, "allocated block not free or reserved")

endmodule

// ===== design/bba_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
